FILE: src/date_period_overlap_days_assert.svh
// assertion macros for the date period overlap block
// they use the clock and reset of the module that includes this file
`ifndef DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH
`define DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH
`ifndef SYNTHESIS
`define DPOD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dpod assertion failed");
`define DPOD_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("dpod reset assertion failed");
`else
`define DPOD_ASSERT(lbl, prop)
`define DPOD_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: src/dpod_pkg.sv
`default_nettype none
package dpod_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int OVERLAP_W = 22;
   localparam int DAYNUM_W  = 23;
   localparam int QUOT_W    = 8;
   localparam int OFFSET_W  = 9;
   localparam int NUM_DATES = 4;

   // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + 1 + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam logic [OVERLAP_W-1:0] OVERLAP_MAX = '1;

   typedef logic [YEAR_W-1:0]    year_type;
   typedef logic [MONTH_W-1:0]   month_type;
   typedef logic [DAY_W-1:0]     day_type;
   typedef logic [OVERLAP_W-1:0] overlap_type;
   typedef logic [DAYNUM_W-1:0]  daynum_type;
   typedef logic [QUOT_W-1:0]    quot_type;
   typedef logic [OFFSET_W-1:0]  offset_type;

   typedef enum logic [MONTH_W-1:0] {
      MON_JAN = 4'd1, MON_FEB = 4'd2, MON_MAR = 4'd3, MON_APR = 4'd4,
      MON_MAY = 4'd5, MON_JUN = 4'd6, MON_JUL = 4'd7, MON_AUG = 4'd8,
      MON_SEP = 4'd9, MON_OCT = 4'd10, MON_NOV = 4'd11, MON_DEC = 4'd12
   } month_code_type;

   // length of a month, zero for a code that is no month
   function automatic day_type month_len(input month_type m, input logic leap);
      day_type len;
      case (m)
         MON_JAN, MON_MAR, MON_MAY, MON_JUL,
         MON_AUG, MON_OCT, MON_DEC:         len = 5'd31;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         MON_FEB:                           len = leap ? 5'd29 : 5'd28;
         default:                           len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the common year before the first of the month
   function automatic offset_type days_before(input month_type m);
      offset_type n;
      case (m)
         MON_JAN: n = 9'd0;
         MON_FEB: n = 9'd31;
         MON_MAR: n = 9'd59;
         MON_APR: n = 9'd90;
         MON_MAY: n = 9'd120;
         MON_JUN: n = 9'd151;
         MON_JUL: n = 9'd181;
         MON_AUG: n = 9'd212;
         MON_SEP: n = 9'd243;
         MON_OCT: n = 9'd273;
         MON_NOV: n = 9'd304;
         MON_DEC: n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

FILE: src/date_period_overlap_days.sv
// date period overlap: counts the calendar days two gregorian periods share
// request channel (req_valid/req_ready) carries one item: start and end date
// of both periods, each date as year, month and day
// response channel (rsp_valid/rsp_ready) returns one item per request:
// rsp_overlap_days (both ends counted, saturates at 4194303) and
// rsp_bad_date (some month or day impossible, count then forced to 0)
// an end before its start makes that period empty, so the count is 0
// the pipe has five register stages, the last of which is the response register
// throughput: one item per cycle unless rsp_ready stalls the pipe; each stage holds one item
// and the day number conversions use constant multipliers only
// a stalled receiver holds the response steady; bubbles inside the pipe
// are squeezed out, and req_ready falls only once every stage is full
// reset (synchronous, active high) empties the pipe; items in flight are lost
`default_nettype none
`include "date_period_overlap_days_assert.svh"
module date_period_overlap_days (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire dpod_pkg::year_type       req_first_start_year,
   input  wire dpod_pkg::month_type      req_first_start_month,
   input  wire dpod_pkg::day_type        req_first_start_day,
   input  wire dpod_pkg::year_type       req_first_end_year,
   input  wire dpod_pkg::month_type      req_first_end_month,
   input  wire dpod_pkg::day_type        req_first_end_day,
   input  wire dpod_pkg::year_type       req_second_start_year,
   input  wire dpod_pkg::month_type      req_second_start_month,
   input  wire dpod_pkg::day_type        req_second_start_day,
   input  wire dpod_pkg::year_type       req_second_end_year,
   input  wire dpod_pkg::month_type      req_second_end_month,
   input  wire dpod_pkg::day_type        req_second_end_day,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output dpod_pkg::overlap_type         rsp_overlap_days,
   output logic                          rsp_bad_date
);
   import dpod_pkg::*;

   // date slots: 0 first start, 1 first end, 2 second start, 3 second end
   year_type   yr   [NUM_DATES];
   month_type  mon  [NUM_DATES];
   day_type    dy   [NUM_DATES];

   // stage enables, a stage takes new data when empty or when it drains
   logic en0, en1, en2, en3, en4;

   // stage 1: quotients by 100 and the year times 365
   logic       vld1_ff;
   year_type   y1_ff    [NUM_DATES];
   month_type  m1_ff    [NUM_DATES];
   day_type    d1_ff    [NUM_DATES];
   quot_type   qy1_ff   [NUM_DATES];
   quot_type   qa1_ff   [NUM_DATES];
   quot_type   qb1_ff   [NUM_DATES];
   daynum_type y365_1_ff[NUM_DATES];
   quot_type   qy1_in   [NUM_DATES];
   quot_type   qa1_in   [NUM_DATES];
   quot_type   qb1_in   [NUM_DATES];
   daynum_type y365_1_in[NUM_DATES];

   // stage 2: days before the year, offset within it, date checks
   logic       vld2_ff;
   logic       ok2_ff;
   daynum_type base2_ff [NUM_DATES];
   offset_type off2_ff  [NUM_DATES];
   logic       ok2_in;
   daynum_type base2_in [NUM_DATES];
   offset_type off2_in  [NUM_DATES];

   // stage 3: day numbers
   logic       vld3_ff;
   logic       ok3_ff;
   daynum_type n3_ff    [NUM_DATES];
   daynum_type n3_in    [NUM_DATES];

   // stage 4: later start, earlier end
   logic       vld4_ff;
   logic       ok4_ff;
   daynum_type lo4_ff;
   daynum_type hi4_ff;
   daynum_type lo4_in;
   daynum_type hi4_in;

   // stage 5: response register
   logic        rsp_valid_ff;
   overlap_type rsp_overlap_days_ff;
   logic        rsp_bad_date_ff;
   overlap_type rsp_overlap_days_in;
   logic        rsp_bad_date_in;

   assign yr[0]  = req_first_start_year;
   assign mon[0] = req_first_start_month;
   assign dy[0]  = req_first_start_day;
   assign yr[1]  = req_first_end_year;
   assign mon[1] = req_first_end_month;
   assign dy[1]  = req_first_end_day;
   assign yr[2]  = req_second_start_year;
   assign mon[2] = req_second_start_month;
   assign dy[2]  = req_second_start_day;
   assign yr[3]  = req_second_end_year;
   assign mon[3] = req_second_end_month;
   assign dy[3]  = req_second_end_day;

   // ready chain from the response register back to the request side
   assign en4       = !rsp_valid_ff || rsp_ready;
   assign en3       = !vld4_ff || en4;
   assign en2       = !vld3_ff || en3;
   assign en1       = !vld2_ff || en2;
   assign en0       = !vld1_ff || en1;
   assign req_ready = en0;

   // stage 1 logic: y/100, (y+99)/100 and (y+399)/100 by reciprocal
   always_comb begin
      logic [YEAR_W:0]   ye;
      logic [PROD_W-1:0] py;
      logic [PROD_W-1:0] pa;
      logic [PROD_W-1:0] pb;
      for (int i = 0; i < NUM_DATES; i++) begin
         ye = {1'b0, yr[i]};
         py = PROD_W'(ye) * PROD_W'(RECIP_100);
         pa = PROD_W'(ye + (YEAR_W+1)'(99)) * PROD_W'(RECIP_100);
         pb = PROD_W'(ye + (YEAR_W+1)'(399)) * PROD_W'(RECIP_100);
         qy1_in[i]    = py[RECIP_SHIFT +: QUOT_W];
         qa1_in[i]    = pa[RECIP_SHIFT +: QUOT_W];
         qb1_in[i]    = pb[RECIP_SHIFT +: QUOT_W];
         y365_1_in[i] = DAYNUM_W'(yr[i]) * DAYNUM_W'(365);
      end
   end

   // stage 2 logic: leap rule, month length check, year base and offset
   always_comb begin
      logic                leap;
      logic                ok_d;
      logic [YEAR_W:0]     hund;
      logic [YEAR_W-2:0]   q4;
      day_type             len;
      ok2_in = 1'b1;
      for (int i = 0; i < NUM_DATES; i++) begin
         hund = (YEAR_W+1)'(qy1_ff[i]) * (YEAR_W+1)'(100);
         leap = (y1_ff[i][1:0] == 2'd0) &&
                ((hund != {1'b0, y1_ff[i]}) || (qy1_ff[i][1:0] == 2'd0));
         len  = month_len(m1_ff[i], leap);
         ok_d = (len != '0) && (d1_ff[i] != '0) && (d1_ff[i] <= len);
         ok2_in = ok2_in && ok_d;
         q4   = (YEAR_W-1)'(({1'b0, y1_ff[i]} + (YEAR_W+1)'(3)) >> 2);
         base2_in[i] = y365_1_ff[i] + DAYNUM_W'(q4) - DAYNUM_W'(qa1_ff[i])
                       + DAYNUM_W'(qb1_ff[i] >> 2);
         off2_in[i]  = days_before(m1_ff[i])
                       + OFFSET_W'(leap && (m1_ff[i] > MON_FEB))
                       + OFFSET_W'(d1_ff[i]) - OFFSET_W'(1);
      end
   end

   // stage 3 logic
   always_comb begin
      for (int i = 0; i < NUM_DATES; i++) begin
         n3_in[i] = base2_ff[i] + DAYNUM_W'(off2_ff[i]);
      end
   end

   // stage 4 logic: intersection bounds
   assign lo4_in = (n3_ff[0] > n3_ff[2]) ? n3_ff[0] : n3_ff[2];
   assign hi4_in = (n3_ff[1] < n3_ff[3]) ? n3_ff[1] : n3_ff[3];

   // stage 5 logic: inclusive count with saturation
   always_comb begin
      logic [DAYNUM_W:0] diff;
      diff = {1'b0, hi4_ff} - {1'b0, lo4_ff} + (DAYNUM_W+1)'(1);
      rsp_overlap_days_in = '0;
      if (ok4_ff && (hi4_ff >= lo4_ff)) begin
         if (diff > (DAYNUM_W+1)'(OVERLAP_MAX)) begin
            rsp_overlap_days_in = OVERLAP_MAX;
         end else begin
            rsp_overlap_days_in = diff[OVERLAP_W-1:0];
         end
      end
      rsp_bad_date_in = !ok4_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         vld4_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) begin
            vld1_ff <= req_valid;
         end
         if (en1) begin
            vld2_ff <= vld1_ff;
         end
         if (en2) begin
            vld3_ff <= vld2_ff;
         end
         if (en3) begin
            vld4_ff <= vld3_ff;
         end
         if (en4) begin
            rsp_valid_ff <= vld4_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en0) begin
         for (int i = 0; i < NUM_DATES; i++) begin
            y1_ff[i]     <= yr[i];
            m1_ff[i]     <= mon[i];
            d1_ff[i]     <= dy[i];
            qy1_ff[i]    <= qy1_in[i];
            qa1_ff[i]    <= qa1_in[i];
            qb1_ff[i]    <= qb1_in[i];
            y365_1_ff[i] <= y365_1_in[i];
         end
      end
      if (en1) begin
         ok2_ff <= ok2_in;
         for (int i = 0; i < NUM_DATES; i++) begin
            base2_ff[i] <= base2_in[i];
            off2_ff[i]  <= off2_in[i];
         end
      end
      if (en2) begin
         ok3_ff <= ok2_ff;
         for (int i = 0; i < NUM_DATES; i++) begin
            n3_ff[i] <= n3_in[i];
         end
      end
      if (en3) begin
         ok4_ff <= ok3_ff;
         lo4_ff <= lo4_in;
         hi4_ff <= hi4_in;
      end
      if (en4) begin
         rsp_overlap_days_ff <= rsp_overlap_days_in;
         rsp_bad_date_ff     <= rsp_bad_date_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_overlap_days = rsp_overlap_days_ff;
   assign rsp_bad_date     = rsp_bad_date_ff;

   // a flagged item never carries a count
   `DPOD_ASSERT(a_bad_gives_zero, rsp_valid_ff && rsp_bad_date_ff |-> rsp_overlap_days_ff == '0)
   // an accepted item lands in the first stage
   `DPOD_ASSERT(a_accept_fills, req_valid && req_ready |=> vld1_ff)
   // back pressure only when every stage is full and the receiver stalls
   `DPOD_ASSERT(a_full_when_stalled, !req_ready |-> vld1_ff && vld2_ff && vld3_ff && vld4_ff && rsp_valid_ff && !rsp_ready)
   // reset empties the response register
   `DPOD_ASSERT_RST(a_reset_empties, reset |=> !rsp_valid_ff)

endmodule
`default_nettype wire
